@@ src/gdfw_pkg.sv @@
`default_nettype none

package gdfw_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int EDGE_SLOTS   = 2 * MAX_EDGES;

  localparam int LABEL_W  = 8;
  localparam int INDEX_W  = 6;
  localparam int VCOUNT_W = 7;

  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_AW = $clog2(EDGE_SLOTS);
  localparam int LINK_W  = $clog2(EDGE_SLOTS + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_SET_LABEL = 2'd1,
    ACT_ADD_EDGE  = 2'd2,
    ACT_START     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } result_status_t;

  typedef struct packed {
    action_t              action;
    logic [INDEX_W-1:0]   vertex_index;
    logic [LABEL_W-1:0]   first_label;
    logic [LABEL_W-1:0]   second_label;
  } command_t;

  typedef struct packed {
    logic [LABEL_W-1:0]   visited_label;
    logic [INDEX_W-1:0]   visited_index;
    result_status_t       status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [VTX_W-1:0]     nbr;
    logic [LINK_W-1:0]    link;
  } edge_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_SET_LABEL,
    DP_ACK,
    DP_SEARCH_STEP,
    DP_LINK_RA,
    DP_LINK_WA,
    DP_LINK_RB,
    DP_LINK_WB,
    DP_VISIT_ROOT,
    DP_VISIT_LOAD,
    DP_EDGE_READ,
    DP_EDGE_TAKE,
    DP_POP,
    DP_POP_LOAD,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t         op;
    result_status_t ack_status;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    srch_done;
    logic    a_found;
    logic    b_found;
    logic    store_full;
    logic    top_null;
    logic    depth_one;
    logic    take_visit;
  } dp_flags_t;

endpackage

`default_nettype wire

@@ src/gdfw_ctrl.sv @@
`default_nettype none

module gdfw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gdfw_pkg::dp_flags_t flags,
  output gdfw_pkg::dp_cmd_t   cmd
);
  import gdfw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_LINK_WA,
    S_LINK_RB,
    S_LINK_WB,
    S_VLOAD,
    S_STEP,
    S_TAKE,
    S_POPLOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next     = state;
    cmd.op         = DP_NONE;
    cmd.ack_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (flags.action)
          ACT_CLEAR: begin
            cmd.op     = DP_CLEAR;
            state_next = S_IDLE;
          end
          ACT_SET_LABEL: begin
            cmd.op     = DP_SET_LABEL;
            state_next = S_IDLE;
          end
          default: state_next = S_SEARCH;
        endcase
      end
      S_SEARCH: begin
        if (!flags.srch_done) begin
          cmd.op = DP_SEARCH_STEP;
        end else if (flags.action == ACT_START) begin
          if (flags.a_found) begin
            cmd.op     = DP_VISIT_ROOT;
            state_next = S_VLOAD;
          end else begin
            cmd.op         = DP_ACK;
            cmd.ack_status = ST_NOT_FOUND;
            state_next     = S_IDLE;
          end
        end else if (!(flags.a_found && flags.b_found)) begin
          cmd.op         = DP_ACK;
          cmd.ack_status = ST_NOT_FOUND;
          state_next     = S_IDLE;
        end else if (flags.store_full) begin
          cmd.op         = DP_ACK;
          cmd.ack_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.op     = DP_LINK_RA;
          state_next = S_LINK_WA;
        end
      end
      S_LINK_WA: begin
        cmd.op     = DP_LINK_WA;
        state_next = S_LINK_RB;
      end
      S_LINK_RB: begin
        cmd.op     = DP_LINK_RB;
        state_next = S_LINK_WB;
      end
      S_LINK_WB: begin
        cmd.op     = DP_LINK_WB;
        state_next = S_IDLE;
      end
      S_VLOAD: begin
        cmd.op     = DP_VISIT_LOAD;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (!flags.top_null) begin
          cmd.op     = DP_EDGE_READ;
          state_next = S_TAKE;
        end else if (flags.depth_one) begin
          cmd.op     = DP_FINISH;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_POP;
          state_next = S_POPLOAD;
        end
      end
      S_TAKE: begin
        cmd.op     = DP_EDGE_TAKE;
        state_next = flags.take_visit ? S_VLOAD : S_STEP;
      end
      S_POPLOAD: begin
        cmd.op     = DP_POP_LOAD;
        state_next = S_STEP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

@@ src/gdfw_dp.sv @@
`default_nettype none

module gdfw_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  gdfw_pkg::command_t               command,
  input  logic                             config_we,
  input  logic [gdfw_pkg::VCOUNT_W-1:0]    config_data,
  input  gdfw_pkg::dp_cmd_t                cmd,
  output gdfw_pkg::dp_flags_t              flags,
  output logic                             done,
  output gdfw_pkg::result_t                result
);
  import gdfw_pkg::*;

  command_t               item;
  logic [VCOUNT_W-1:0]    vertex_count;
  logic [VCOUNT_W-1:0]    active_n;
  logic [VCOUNT_W-1:0]    srch_idx;
  logic                   cmp_vld;
  logic [VTX_W-1:0]       cmp_idx;
  logic                   a_found;
  logic                   b_found;
  logic [VTX_W-1:0]       a_idx;
  logic [VTX_W-1:0]       b_idx;
  logic                   match_a;
  logic                   match_b;
  logic                   issue;

  logic [LABEL_W-1:0]     label_mem [MAX_VERTICES];
  logic [LABEL_W-1:0]     label_rd;
  logic [VTX_W-1:0]       label_raddr;
  logic                   label_we;

  logic [LINK_W-1:0]      head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_vld;
  logic [LINK_W-1:0]      head_rd;
  logic                   head_rd_vld;
  logic [LINK_W-1:0]      head_link;
  logic [VTX_W-1:0]       head_raddr;
  logic [VTX_W-1:0]       head_waddr;
  logic                   head_we;

  edge_t                  edge_mem [EDGE_SLOTS];
  edge_t                  edge_rd;
  edge_t                  edge_wdata;
  logic [EDGE_AW-1:0]     edge_raddr;
  logic [LINK_W-1:0]      top_prev;
  logic [LINK_W-1:0]      edge_used;
  logic [LINK_W-1:0]      new_link;

  logic [LINK_W-1:0]      stack_mem [MAX_VERTICES];
  logic [LINK_W-1:0]      stack_rd;
  logic [DEPTH_W-1:0]     depth;
  logic [DEPTH_W-1:0]     depth_m1;
  logic [DEPTH_W-1:0]     depth_m2;
  logic                   push;

  logic [MAX_VERTICES-1:0] visited;
  logic [LINK_W-1:0]      top_link;
  logic [VTX_W-1:0]       cur_v;
  logic                   pend_vld;
  logic [LABEL_W-1:0]     pend_label;
  logic [VTX_W-1:0]       pend_idx;
  logic                   take_visit;
  logic                   ack;

  assign active_n = (vertex_count > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES)
                                                             : vertex_count;
  assign issue    = (srch_idx < active_n);
  assign match_a  = (cmd.op == DP_SEARCH_STEP) && cmp_vld && !a_found &&
                    (label_rd == item.first_label);
  assign match_b  = (cmd.op == DP_SEARCH_STEP) && cmp_vld && !b_found &&
                    (label_rd == item.second_label);

  assign head_link  = head_rd_vld ? head_rd : '0;
  assign new_link   = edge_used + LINK_W'(1);
  assign top_prev   = top_link - LINK_W'(1);
  assign edge_raddr = top_prev[EDGE_AW-1:0];
  assign depth_m1   = depth - DEPTH_W'(1);
  assign depth_m2   = depth - DEPTH_W'(2);
  assign take_visit = !visited[edge_rd.nbr] && (depth < DEPTH_W'(MAX_VERTICES));
  assign push       = (cmd.op == DP_EDGE_TAKE) && take_visit;
  assign head_we    = (cmd.op == DP_LINK_WA) || (cmd.op == DP_LINK_WB);
  assign head_waddr = (cmd.op == DP_LINK_WB) ? b_idx : a_idx;
  assign label_we   = (cmd.op == DP_SET_LABEL) &&
                      ({1'b0, item.vertex_index} < (INDEX_W + 1)'(MAX_VERTICES));
  assign ack        = (cmd.op == DP_CLEAR) || (cmd.op == DP_SET_LABEL) ||
                      (cmd.op == DP_ACK) || (cmd.op == DP_LINK_WB);

  always_comb begin
    edge_wdata.nbr  = (cmd.op == DP_LINK_WB) ? a_idx : b_idx;
    edge_wdata.link = head_link;
  end

  always_comb begin
    case (cmd.op)
      DP_SEARCH_STEP: label_raddr = srch_idx[VTX_W-1:0];
      DP_VISIT_ROOT:  label_raddr = a_idx;
      DP_EDGE_TAKE:   label_raddr = edge_rd.nbr;
      default:        label_raddr = cur_v;
    endcase
    case (cmd.op)
      DP_LINK_RA:    head_raddr = a_idx;
      DP_LINK_RB:    head_raddr = b_idx;
      DP_VISIT_ROOT: head_raddr = a_idx;
      DP_EDGE_TAKE:  head_raddr = edge_rd.nbr;
      default:       head_raddr = cur_v;
    endcase
  end

  always_comb begin
    flags.action     = item.action;
    flags.srch_done  = (!cmp_vld && !issue) ||
                       (a_found && (b_found || item.action == ACT_START));
    flags.a_found    = a_found;
    flags.b_found    = b_found;
    flags.store_full = ({1'b0, edge_used} + (LINK_W + 1)'(2)) > (LINK_W + 1)'(EDGE_SLOTS);
    flags.top_null   = (top_link == '0);
    flags.depth_one  = (depth == DEPTH_W'(1));
    flags.take_visit = take_visit;
  end

  // label store
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[item.vertex_index[VTX_W-1:0]] <= item.first_label;
    end
    label_rd <= label_mem[label_raddr];
  end

  // list heads
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= new_link;
    end
    head_rd <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == DP_CLEAR) begin
      head_vld <= '0;
    end else if (head_we) begin
      head_vld[head_waddr] <= 1'b1;
    end
    head_rd_vld <= head_vld[head_raddr];
  end

  // edge entries
  always_ff @(posedge clk) begin
    if (head_we) begin
      edge_mem[edge_used[EDGE_AW-1:0]] <= edge_wdata;
    end
    edge_rd <= edge_mem[edge_raddr];
  end

  // walk stack below the top entry
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[depth_m1[VTX_W-1:0]] <= edge_rd.link;
    end
    stack_rd <= stack_mem[depth_m2[VTX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      edge_used    <= '0;
      depth        <= '0;
      visited      <= '0;
      pend_vld     <= 1'b0;
      done         <= 1'b0;
      srch_idx     <= '0;
      cmp_vld      <= 1'b0;
      a_found      <= 1'b0;
      b_found      <= 1'b0;
    end else begin
      if (config_we) begin
        vertex_count <= config_data;
      end
      done <= ack || (cmd.op == DP_FINISH) || ((cmd.op == DP_VISIT_LOAD) && pend_vld);
      if (match_a) begin
        a_found <= 1'b1;
      end
      if (match_b) begin
        b_found <= 1'b1;
      end
      case (cmd.op)
        DP_LOAD: begin
          srch_idx <= '0;
          cmp_vld  <= 1'b0;
          a_found  <= 1'b0;
          b_found  <= 1'b0;
        end
        DP_CLEAR: begin
          edge_used <= '0;
          visited   <= '0;
          depth     <= '0;
        end
        DP_SEARCH_STEP: begin
          cmp_vld <= issue;
          if (issue) begin
            srch_idx <= srch_idx + VCOUNT_W'(1);
          end
        end
        DP_LINK_WA, DP_LINK_WB: edge_used <= new_link;
        DP_VISIT_ROOT: begin
          visited  <= MAX_VERTICES'(1) << a_idx;
          depth    <= DEPTH_W'(1);
          pend_vld <= 1'b0;
        end
        DP_VISIT_LOAD: begin
          pend_vld <= 1'b1;
        end
        DP_EDGE_TAKE: begin
          if (take_visit) begin
            visited[edge_rd.nbr] <= 1'b1;
            depth                <= depth + DEPTH_W'(1);
          end
        end
        DP_POP: depth <= depth_m1;
        DP_FINISH: begin
          depth    <= '0;
          pend_vld <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (match_a) begin
      a_idx <= cmp_idx;
    end
    if (match_b) begin
      b_idx <= cmp_idx;
    end
    if (ack) begin
      result.visited_label <= '0;
      result.visited_index <= '0;
      result.status        <= cmd.ack_status;
      result.last          <= 1'b1;
    end
    case (cmd.op)
      DP_LOAD: item <= command;
      DP_SEARCH_STEP: cmp_idx <= srch_idx[VTX_W-1:0];
      DP_VISIT_ROOT: cur_v <= a_idx;
      DP_VISIT_LOAD: begin
        top_link             <= head_link;
        pend_label           <= label_rd;
        pend_idx             <= cur_v;
        result.visited_label <= pend_label;
        result.visited_index <= INDEX_W'(pend_idx);
        result.status        <= ST_OK;
        result.last          <= 1'b0;
      end
      DP_EDGE_TAKE: begin
        top_link <= edge_rd.link;
        cur_v    <= edge_rd.nbr;
      end
      DP_POP_LOAD: top_link <= stack_rd;
      DP_FINISH: begin
        result.visited_label <= pend_label;
        result.visited_index <= INDEX_W'(pend_idx);
        result.status        <= ST_OK;
        result.last          <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/graph_depth_first_walk.sv @@
`default_nettype none

// Depth-first walk over an undirected graph held in adjacency lists. An item is taken when
// start is high and busy is low; each result is on the result port for one cycle with done
// high and must be taken then, as there is no back-pressure. Clear and set_label give their
// one result without a search. add_edge and start first search the label store through
// its single read port, one vertex per cycle, over up to vertex_count, capped at 64; an
// edge add then makes its two list insertions, reading and writing each list head in turn.
// A walk reads and then takes each edge entry followed, loads each vertex visited, and pops
// the stack then loads the new top, bounded by the edge store and stack memory ports. Each
// visit is delivered when the next one is found or when the walk ends, so the final one
// carries last. Results with a non-zero status carry zero label and index.
module graph_depth_first_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  gdfw_pkg::command_t            command,
  input  logic                          config_we,
  input  logic [gdfw_pkg::VCOUNT_W-1:0] config_data,
  output logic                          done,
  output gdfw_pkg::result_t             result
);
  import gdfw_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  gdfw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  gdfw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .config_we   (config_we),
    .config_data (config_data),
    .cmd         (cmd),
    .flags       (flags),
    .done        (done),
    .result      (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted without going busy");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in progress");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.last && result.visited_label == '0)
    else $error("error result not final or carries a label");

  a_inner_ok: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> result.status == ST_OK && busy)
    else $error("non-final result outside a walk");

endmodule

`default_nettype wire
